FILE: hdl/frame_extreme_pixel_statistics_unit_assert.svh
// Assertion macros used by the checker of the frame statistics unit.
`ifndef FRAME_EXTREME_PIXEL_STATISTICS_UNIT_ASSERT_SVH
`define FRAME_EXTREME_PIXEL_STATISTICS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FEPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame statistics check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FEPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame statistics check failed");

`endif

FILE: hdl/feps_pkg.sv
// Package with the types and constants of the frame statistics unit.
`timescale 1ns / 1ps

package feps_pkg;

	// Default coordinate width.
	localparam int COORD_BITS_DEF = 12;

	// Largest possible R+G+B.
	localparam logic [9:0] SUM_LIMIT = 10'd765;

	// Number of reports per frame and of report sets the queue holds.
	localparam int NUM_REPORTS = 8;
	localparam int SNAP_DEPTH  = 2;

	// Configuration port.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int DIM_W      = 13;
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// Report kinds in the order they leave the block.
	typedef enum logic [2:0] {
		KIND_MAX_SUM = 3'd0,
		KIND_MIN_SUM = 3'd1,
		KIND_MAX_R   = 3'd2,
		KIND_MAX_G   = 3'd3,
		KIND_MAX_B   = 3'd4,
		KIND_MIN_R   = 3'd5,
		KIND_MIN_G   = 3'd6,
		KIND_MIN_B   = 3'd7
	} stat_kind_t;

	// Handshake between the tracking front and the report back end.
	typedef struct packed {
		logic push;
		logic full;
	} snap_ctl_t;

endpackage

FILE: hdl/feps_if.sv
// Channel interfaces: pixel requests in, report requests out.
`timescale 1ns / 1ps

interface feps_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface feps_rpt_if #(parameter int COORD_BITS = 12);
	logic                  valid;
	logic                  ready;
	logic [2:0]            stat_kind;
	logic [COORD_BITS-1:0] x_pos;
	logic [COORD_BITS-1:0] y_pos;
	logic [9:0]            extreme_value;
	logic [7:0]            pix_red;
	logic [7:0]            pix_green;
	logic [7:0]            pix_blue;
	logic                  last_of_report;

	modport source (output valid, output stat_kind, output x_pos, output y_pos,
		output extreme_value, output pix_red, output pix_green, output pix_blue,
		output last_of_report, input ready);
	modport sink (input valid, input stat_kind, input x_pos, input y_pos,
		input extreme_value, input pix_red, input pix_green, input pix_blue,
		input last_of_report, output ready);
endinterface

FILE: hdl/feps_cfg.sv
// APB-style configuration registers for frame width and height.
`timescale 1ns / 1ps

module feps_cfg import feps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [DIM_W-1:0]      frame_width,
	output logic [DIM_W-1:0]      frame_height
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             wr_en;
	cfg_reg_t         reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = cfg_reg_t'(paddr[2]);

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_FRAME_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_FRAME_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data is the stored value, zero extended.
	always_comb begin
		unique case (reg_sel)
			REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(width_q);
			REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(height_q);
			default:          prdata = '0;
		endcase
	end

	assign frame_width  = width_q;
	assign frame_height = height_q;

endmodule

FILE: hdl/feps_front.sv
// Front end: accepts pixels, counts position and updates the extreme trackers.
`timescale 1ns / 1ps

module feps_front import feps_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	feps_pix_if.sink              pix,
	input  logic [DIM_W-1:0]      frame_width,
	input  logic [DIM_W-1:0]      frame_height,
	input  logic                  snap_full,
	output logic                  snap_push,
	output logic [9:0]            snap_val [NUM_REPORTS],
	output logic [COORD_BITS-1:0] snap_x   [NUM_REPORTS],
	output logic [COORD_BITS-1:0] snap_y   [NUM_REPORTS],
	output logic [23:0]           snap_rgb [2]
);

	localparam int CB = COORD_BITS;
	localparam int DW = (CB + 1 > DIM_W) ? CB + 1 : DIM_W;
	localparam logic [DW-1:0] DIM_LIMIT = DW'(1) << CB;

	// Clamp a configured dimension to 1..2^CB and return it minus one.
	function automatic logic [CB-1:0] last_index(input logic [DIM_W-1:0] dim);
		logic [DW-1:0] ext;
		logic [DW-1:0] clamped;
		ext = DW'(dim);
		if (ext == '0)
			clamped = DW'(1);
		else if (ext > DIM_LIMIT)
			clamped = DIM_LIMIT;
		else
			clamped = ext;
		return CB'(clamped - DW'(1));
	endfunction

	logic [CB-1:0] col_q;
	logic [CB-1:0] row_q;
	logic [CB-1:0] wm1;
	logic [CB-1:0] hm1;
	logic          row_more;
	logic          frame_more;
	logic          at_end;
	logic          accept;
	logic          first;
	logic [9:0]    sum;
	logic [7:0]    px [3];

	// Tracker registers: index 0 maximum, 1 minimum for the sums;
	// 0..2 maximum R/G/B and 3..5 minimum R/G/B for the channels.
	logic [9:0]    sv_q  [2];
	logic [CB-1:0] sx_q  [2];
	logic [CB-1:0] sy_q  [2];
	logic [23:0]   srgb_q[2];
	logic [7:0]    cv_q  [6];
	logic [CB-1:0] cx_q  [6];
	logic [CB-1:0] cy_q  [6];

	logic [9:0]    sv_n  [2];
	logic [CB-1:0] sx_n  [2];
	logic [CB-1:0] sy_n  [2];
	logic [23:0]   srgb_n[2];
	logic [7:0]    cv_n  [6];
	logic [CB-1:0] cx_n  [6];
	logic [CB-1:0] cy_n  [6];

	// Position decode against the current dimensions.
	assign wm1        = last_index(frame_width);
	assign hm1        = last_index(frame_height);
	assign row_more   = col_q < wm1;
	assign frame_more = row_q < hm1;
	assign at_end     = !row_more && !frame_more;

	// A frame-closing pixel waits only while the report queue is full.
	assign pix.ready = !(at_end && snap_full);
	assign accept    = pix.valid && pix.ready;
	assign snap_push = accept && at_end;

	assign px[0] = pix.red;
	assign px[1] = pix.green;
	assign px[2] = pix.blue;
	assign sum   = 10'(pix.red) + 10'(pix.green) + 10'(pix.blue);
	assign first = (col_q == '0) && (row_q == '0);

	// Tracker update: the first pixel of a frame loads every tracker,
	// later pixels replace only on a strictly more extreme value.
	always_comb begin
		sv_n   = sv_q;
		sx_n   = sx_q;
		sy_n   = sy_q;
		srgb_n = srgb_q;
		cv_n   = cv_q;
		cx_n   = cx_q;
		cy_n   = cy_q;
		if (first || sum > sv_q[0]) begin
			sv_n[0]   = sum;
			sx_n[0]   = col_q;
			sy_n[0]   = row_q;
			srgb_n[0] = {pix.red, pix.green, pix.blue};
		end
		if (first || sum < sv_q[1]) begin
			sv_n[1]   = sum;
			sx_n[1]   = col_q;
			sy_n[1]   = row_q;
			srgb_n[1] = {pix.red, pix.green, pix.blue};
		end
		for (int c = 0; c < 3; c++) begin
			if (first || px[c] > cv_q[c]) begin
				cv_n[c] = px[c];
				cx_n[c] = col_q;
				cy_n[c] = row_q;
			end
			if (first || px[c] < cv_q[c+3]) begin
				cv_n[c+3] = px[c];
				cx_n[c+3] = col_q;
				cy_n[c+3] = row_q;
			end
		end
	end

	// Report set for the queue, taken from the updated trackers.
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			snap_val[k] = sv_n[k];
			snap_x[k]   = sx_n[k];
			snap_y[k]   = sy_n[k];
			snap_rgb[k] = srgb_n[k];
		end
		for (int k = 0; k < 6; k++) begin
			snap_val[k+2] = 10'(cv_n[k]);
			snap_x[k+2]   = cx_n[k];
			snap_y[k+2]   = cy_n[k];
		end
	end

	// Column and row counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_more) begin
				col_q <= col_q + CB'(1);
			end else begin
				col_q <= '0;
				if (frame_more)
					row_q <= row_q + CB'(1);
				else
					row_q <= '0;
			end
		end
	end

	// Trackers hold payload only; every frame starts at the origin and reloads them.
	always_ff @(posedge clk) begin
		if (accept) begin
			sv_q   <= sv_n;
			sx_q   <= sx_n;
			sy_q   <= sy_n;
			srgb_q <= srgb_n;
			cv_q   <= cv_n;
			cx_q   <= cx_n;
			cy_q   <= cy_n;
		end
	end

endmodule

FILE: hdl/feps_back.sv
// Back end: queue of finished report sets and the report serializer.
`timescale 1ns / 1ps

module feps_back import feps_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  snap_push,
	output logic                  snap_full,
	input  logic [9:0]            snap_val [NUM_REPORTS],
	input  logic [COORD_BITS-1:0] snap_x   [NUM_REPORTS],
	input  logic [COORD_BITS-1:0] snap_y   [NUM_REPORTS],
	input  logic [23:0]           snap_rgb [2],
	feps_rpt_if.source            rpt
);

	localparam int CB = COORD_BITS;
	localparam int QD = SNAP_DEPTH;
	localparam int PW = (QD > 1) ? $clog2(QD) : 1;
	localparam int CW = $clog2(QD + 1);

	logic [9:0]    q_val_q [QD][NUM_REPORTS];
	logic [CB-1:0] q_x_q   [QD][NUM_REPORTS];
	logic [CB-1:0] q_y_q   [QD][NUM_REPORTS];
	logic [23:0]   q_rgb_q [QD][2];

	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	stat_kind_t    kind_q;
	logic          load;
	logic          pop;
	logic          is_sum;

	logic                  out_valid_q;
	logic [2:0]            out_kind_q;
	logic [CB-1:0]         out_x_q;
	logic [CB-1:0]         out_y_q;
	logic [9:0]            out_val_q;
	logic [23:0]           out_rgb_q;
	logic                  out_last_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(QD - 1)) ? '0 : p + PW'(1);
	endfunction

	assign snap_full = cnt_q == CW'(QD);
	assign load      = (cnt_q != '0) && (!out_valid_q || rpt.ready);
	assign pop       = load && (kind_q == KIND_MIN_B);
	assign is_sum    = (kind_q == KIND_MAX_SUM) || (kind_q == KIND_MIN_SUM);

	// Queue storage is written only on a push.
	always_ff @(posedge clk) begin
		if (snap_push) begin
			q_val_q[wr_q] <= snap_val;
			q_x_q[wr_q]   <= snap_x;
			q_y_q[wr_q]   <= snap_y;
			q_rgb_q[wr_q] <= snap_rgb;
		end
	end

	// Queue pointers, fill count and the kind of the next report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			cnt_q  <= '0;
			kind_q <= KIND_MAX_SUM;
		end else begin
			if (snap_push)
				wr_q <= ptr_inc(wr_q);
			if (pop)
				rd_q <= ptr_inc(rd_q);
			if (snap_push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !snap_push)
				cnt_q <= cnt_q - CW'(1);
			if (load)
				kind_q <= stat_kind_t'(kind_q + 3'd1);
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (rpt.ready)
			out_valid_q <= 1'b0;
	end

	// Output register payload; component reports carry no pixel color.
	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q <= kind_q;
			out_x_q    <= q_x_q[rd_q][kind_q];
			out_y_q    <= q_y_q[rd_q][kind_q];
			out_val_q  <= q_val_q[rd_q][kind_q];
			out_rgb_q  <= is_sum ? q_rgb_q[rd_q][kind_q[0]] : 24'd0;
			out_last_q <= kind_q == KIND_MIN_B;
		end
	end

	assign rpt.valid          = out_valid_q;
	assign rpt.stat_kind      = out_kind_q;
	assign rpt.x_pos          = out_x_q;
	assign rpt.y_pos          = out_y_q;
	assign rpt.extreme_value  = out_val_q;
	assign rpt.pix_red        = out_rgb_q[23:16];
	assign rpt.pix_green      = out_rgb_q[15:8];
	assign rpt.pix_blue       = out_rgb_q[7:0];
	assign rpt.last_of_report = out_last_q;

endmodule

FILE: hdl/frame_extreme_pixel_statistics_unit.sv
// Top level of the frame extreme-pixel statistics unit.
// Usage:
// Pixels enter on the pix channel in raster order, one request per pixel.
// The block counts column and row itself against frame_width and
// frame_height, written over the APB port at byte addresses 0 and 4.
// It tracks the brightest and darkest pixel by R+G+B and the maximum and
// minimum of each channel, each with the position of its first occurrence.
// After the last pixel of a frame it sends eight report requests on rpt:
// max sum, min sum, max R/G/B, min R/G/B; the eighth has last_of_report set.
// Throughput: one pixel per cycle, except that a frame-closing pixel waits
// while the report queue is full. A frame's report set enters the queue when
// its last pixel is taken; the output register then takes one report per cycle while rpt.ready stays high.
// Finished report sets wait in a two-entry queue, so pixels keep flowing
// while reports drain or the receiver stalls. A frame-closing pixel is held
// off only while two report sets still have reports waiting to be sent.
// Reset clears the counters, the report queue and the output valid flag, and
// loads width 640 and height 480.
`timescale 1ns / 1ps

module frame_extreme_pixel_statistics_unit import feps_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	feps_pix_if.sink              pix,
	feps_rpt_if.source            rpt,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [DIM_W-1:0]      frame_width;
	logic [DIM_W-1:0]      frame_height;
	snap_ctl_t             snap_ctl;
	logic [9:0]            snap_val [NUM_REPORTS];
	logic [COORD_BITS-1:0] snap_x   [NUM_REPORTS];
	logic [COORD_BITS-1:0] snap_y   [NUM_REPORTS];
	logic [23:0]           snap_rgb [2];

	feps_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.frame_width  (frame_width),
		.frame_height (frame_height)
	);

	feps_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix          (pix),
		.frame_width  (frame_width),
		.frame_height (frame_height),
		.snap_full    (snap_ctl.full),
		.snap_push    (snap_ctl.push),
		.snap_val     (snap_val),
		.snap_x       (snap_x),
		.snap_y       (snap_y),
		.snap_rgb     (snap_rgb)
	);

	feps_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.snap_push (snap_ctl.push),
		.snap_full (snap_ctl.full),
		.snap_val  (snap_val),
		.snap_x    (snap_x),
		.snap_y    (snap_y),
		.snap_rgb  (snap_rgb),
		.rpt       (rpt)
	);

endmodule

FILE: hdl/feps_checker.sv
// Port-level checker for the frame statistics unit and its bind statement.
`timescale 1ns / 1ps
`include "frame_extreme_pixel_statistics_unit_assert.svh"

module feps_checker import feps_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rpt_valid,
	input logic                  rpt_ready,
	input logic [2:0]            rpt_stat_kind,
	input logic [COORD_BITS-1:0] rpt_x_pos,
	input logic [9:0]            rpt_extreme_value,
	input logic [7:0]            rpt_pix_red,
	input logic [7:0]            rpt_pix_green,
	input logic [7:0]            rpt_pix_blue,
	input logic                  rpt_last_of_report
);

	logic [2:0] exp_kind_q;
	logic       rpt_take;
	logic       comp_kind;

	assign rpt_take  = rpt_valid && rpt_ready;
	assign comp_kind = (rpt_stat_kind != KIND_MAX_SUM) && (rpt_stat_kind != KIND_MIN_SUM);

	// Kind expected on the next report: reports cycle through all eight in order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			exp_kind_q <= KIND_MAX_SUM;
		else if (rpt_take)
			exp_kind_q <= exp_kind_q + 3'd1;
	end

	// A stalled report keeps its kind, column and value.
	`FEPS_ASSERT_NEXT(a_rpt_hold, clk, arst_n, rpt_valid && !rpt_ready,
		rpt_valid && $stable(rpt_stat_kind) && $stable(rpt_x_pos) && $stable(rpt_extreme_value))

	// Reports leave in the fixed order, never skipping or repeating a kind.
	`FEPS_ASSERT_IMPLY(a_rpt_order, clk, arst_n, rpt_valid, rpt_stat_kind == exp_kind_q)

	// The last flag marks exactly the minimum blue report.
	`FEPS_ASSERT_IMPLY(a_rpt_last, clk, arst_n, rpt_valid,
		rpt_last_of_report == (rpt_stat_kind == KIND_MIN_B))

	// Component reports carry a byte value and no pixel color.
	`FEPS_ASSERT_IMPLY(a_rpt_comp, clk, arst_n, rpt_valid && comp_kind,
		rpt_extreme_value <= 10'd255 && rpt_pix_red == 8'd0 && rpt_pix_green == 8'd0 && rpt_pix_blue == 8'd0)

endmodule

bind frame_extreme_pixel_statistics_unit feps_checker #(.COORD_BITS(COORD_BITS)) u_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.rpt_valid          (rpt.valid),
	.rpt_ready          (rpt.ready),
	.rpt_stat_kind      (rpt.stat_kind),
	.rpt_x_pos          (rpt.x_pos),
	.rpt_extreme_value  (rpt.extreme_value),
	.rpt_pix_red        (rpt.pix_red),
	.rpt_pix_green      (rpt.pix_green),
	.rpt_pix_blue       (rpt.pix_blue),
	.rpt_last_of_report (rpt.last_of_report)
);

FILE: tb/sv/frame_extreme_pixel_statistics_unit_tb.sv
// Self-checking testbench for the frame extreme-pixel statistics unit.
`timescale 1ns / 1ps

module frame_extreme_pixel_statistics_unit_tb;
	import feps_pkg::*;

	localparam int RANDOM_ITEMS  = 216;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 150;
	localparam int WATCHDOG_NS   = 2_000_000;
	localparam int MAX_SHOWN     = 10;

	// One report request as it leaves the block.
	typedef struct packed {
		stat_kind_t                kind;
		logic [COORD_BITS_DEF-1:0] x;
		logic [COORD_BITS_DEF-1:0] y;
		logic [9:0]                value;
		logic [7:0]                r;
		logic [7:0]                g;
		logic [7:0]                b;
		logic                      last;
	} stat_report_t;

	// Tracks the frame extremes from the accepted pixels and holds the reports
	// that the block still owes.
	class frame_extremes;
		logic [DIM_W-1:0]          width_reg;
		logic [DIM_W-1:0]          height_reg;
		int                        col;
		int                        row;
		logic [9:0]                best_val [NUM_REPORTS];
		logic [COORD_BITS_DEF-1:0] best_x [NUM_REPORTS];
		logic [COORD_BITS_DEF-1:0] best_y [NUM_REPORTS];
		logic [7:0]                best_r [NUM_REPORTS];
		logic [7:0]                best_g [NUM_REPORTS];
		logic [7:0]                best_b [NUM_REPORTS];
		stat_report_t              awaited [$];
		int                        mismatches;

		function new();
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			col = 0;
			row = 0;
			mismatches = 0;
			clear_trackers();
		endfunction

		function bit seeks_max(stat_kind_t kind);
			case (kind)
				KIND_MAX_SUM, KIND_MAX_R, KIND_MAX_G, KIND_MAX_B: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		function void clear_trackers();
			int k;
			for (k = 0; k < NUM_REPORTS; k++) begin
				best_val[k] = seeks_max(stat_kind_t'(k)) ? 10'd0 : SUM_LIMIT;
				best_x[k] = '0;
				best_y[k] = '0;
				best_r[k] = '0;
				best_g[k] = '0;
				best_b[k] = '0;
			end
		endfunction

		// Zero counts as one; anything past the coordinate range is clipped.
		function int eff_dim(logic [DIM_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > (1 << COORD_BITS_DEF))
				return 1 << COORD_BITS_DEF;
			return int'(v);
		endfunction

		function void set_dim(cfg_reg_t idx, logic [DIM_W-1:0] v);
			if (idx == REG_FRAME_WIDTH)
				width_reg = v;
			else
				height_reg = v;
		endfunction

		function void log_mismatch(string what);
			mismatches++;
			if (mismatches <= MAX_SHOWN)
				$display("%s", what);
		endfunction

		function string show(stat_report_t rep);
			return $sformatf("kind %0d at (%0d,%0d) value %0d rgb %0d/%0d/%0d last %0b",
				rep.kind, rep.x, rep.y, rep.value, rep.r, rep.g, rep.b, rep.last);
		endfunction

		// Update every tracker with one accepted pixel and advance the raster
		// position; the frame's last pixel queues the eight reports.
		function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			stat_kind_t   kind;
			logic [9:0]   v;
			bit           lead;
			bit           beats;
			int           k;
			stat_report_t rep;
			lead = (col == 0) && (row == 0);
			for (k = 0; k < NUM_REPORTS; k++) begin
				kind = stat_kind_t'(k);
				case (kind)
					KIND_MAX_SUM, KIND_MIN_SUM: v = {2'b00, r} + {2'b00, g} + {2'b00, b};
					KIND_MAX_R, KIND_MIN_R: v = {2'b00, r};
					KIND_MAX_G, KIND_MIN_G: v = {2'b00, g};
					default: v = {2'b00, b};
				endcase
				beats = seeks_max(kind) ? (v > best_val[k]) : (v < best_val[k]);
				if (lead || beats) begin
					best_val[k] = v;
					best_x[k] = col[COORD_BITS_DEF-1:0];
					best_y[k] = row[COORD_BITS_DEF-1:0];
					best_r[k] = r;
					best_g[k] = g;
					best_b[k] = b;
				end
			end
			if (col < eff_dim(width_reg) - 1) begin
				col++;
				return;
			end
			col = 0;
			if (row < eff_dim(height_reg) - 1) begin
				row++;
				return;
			end
			row = 0;
			for (k = 0; k < NUM_REPORTS; k++) begin
				kind = stat_kind_t'(k);
				rep.kind = kind;
				rep.x = best_x[k];
				rep.y = best_y[k];
				rep.value = best_val[k];
				// Only the sum reports carry the pixel's components.
				if (kind == KIND_MAX_SUM || kind == KIND_MIN_SUM) begin
					rep.r = best_r[k];
					rep.g = best_g[k];
					rep.b = best_b[k];
				end else begin
					rep.r = '0;
					rep.g = '0;
					rep.b = '0;
				end
				rep.last = (kind == KIND_MIN_B);
				awaited.push_back(rep);
			end
			clear_trackers();
		endfunction

		function void check_report(stat_report_t got);
			stat_report_t want;
			if (awaited.size() == 0) begin
				log_mismatch({"unexpected report: ", show(got)});
				return;
			end
			want = awaited.pop_front();
			if (got.kind != want.kind || got.x != want.x || got.y != want.y ||
					got.value != want.value || got.r != want.r || got.g != want.g ||
					got.b != want.b || got.last != want.last)
				log_mismatch({"report mismatch: expected ", show(want), ", got ", show(got)});
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	feps_pix_if pix_ch ();
	feps_rpt_if #(.COORD_BITS(COORD_BITS_DEF)) rpt_ch ();

	bit src_idle_en = 1'b1;
	bit sink_idle_en = 1'b1;
	bit long_hold_req = 1'b0;

	frame_extremes board = new();

	frame_extreme_pixel_statistics_unit #(.COORD_BITS(COORD_BITS_DEF)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix_ch),
		.rpt     (rpt_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #2 clk = ~clk;

	// Watch both channels at the rising edge.
	always @(posedge clk) begin : watch_channels
		stat_report_t got;
		if (arst_n && pix_ch.valid && pix_ch.ready)
			board.note_pixel(pix_ch.red, pix_ch.green, pix_ch.blue);
		if (arst_n && rpt_ch.valid && rpt_ch.ready) begin
			got.kind = stat_kind_t'(rpt_ch.stat_kind);
			got.x = rpt_ch.x_pos;
			got.y = rpt_ch.y_pos;
			got.value = rpt_ch.extreme_value;
			got.r = rpt_ch.pix_red;
			got.g = rpt_ch.pix_green;
			got.b = rpt_ch.pix_blue;
			got.last = rpt_ch.last_of_report;
			board.check_report(got);
		end
	end

	// Report receiver: random stall bursts, plus one long hold-off on request.
	initial begin : report_sink
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		rpt_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				hold_left = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rpt_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rpt_ch.ready <= 1'b0;
			end else begin
				rpt_ch.ready <= 1'b1;
				if (sink_idle_en && $urandom_range(0, 4) == 0)
					stall_left = $urandom_range(1, 6);
			end
		end
	end

	// Watchdog for a hung run.
	initial begin : watchdog
		#(WATCHDOG_NS);
		$display("frame_extreme_pixel_statistics_unit regression: fail");
		$finish;
	end

	function automatic logic [CFG_ADDR_W-1:0] reg_addr(cfg_reg_t idx);
		return {idx, 2'b00};
	endfunction

	// APB write: setup cycle, then access cycle until pready.
	task automatic apb_write(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
		logic [CFG_DATA_W-1:0] wdata;
		wdata = $urandom;
		wdata[DIM_W-1:0] = val;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= reg_addr(idx);
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_dim(idx, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read_check(input cfg_reg_t idx, input logic [DIM_W-1:0] want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= reg_addr(idx);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {{(CFG_DATA_W - DIM_W){1'b0}}, want})
			board.log_mismatch($sformatf("register %0d read: expected %0d, got %0h",
				idx, want, prdata));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Offer one pixel request, after an optional idle burst, and wait until taken.
	task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		gap = (src_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
		@(negedge clk);
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.red <= r;
		pix_ch.green <= g;
		pix_ch.blue <= b;
		do @(posedge clk); while (!pix_ch.ready);
	endtask

	// Pixels in a mix of styles; the shared base makes ties across a batch.
	task automatic send_random(input int n);
		logic [7:0] c [3];
		int style;
		int base;
		int i;
		int j;
		base = $urandom_range(0, 253);
		for (i = 0; i < n; i++) begin
			style = $urandom_range(0, 3);
			for (j = 0; j < 3; j++) begin
				case (style)
					0: c[j] = 8'($urandom);
					1: c[j] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					2: c[j] = 8'(base + $urandom_range(0, 2));
					default: c[j] = 8'(base);
				endcase
			end
			push_pixel(c[0], c[1], c[2]);
		end
	endtask

	// Stop offering pixels and let every owed report drain.
	task automatic quiesce();
		@(negedge clk);
		pix_ch.valid <= 1'b0;
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reconfigure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		quiesce();
		apb_write(REG_FRAME_WIDTH, w);
		apb_write(REG_FRAME_HEIGHT, h);
		apb_read_check(REG_FRAME_WIDTH, w);
		apb_read_check(REG_FRAME_HEIGHT, h);
	endtask

	initial begin : main_seq
		int sent;
		int n;
		int fw;
		int fh;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;

		pix_ch.valid = 1'b0;
		pix_ch.red = '0;
		pix_ch.green = '0;
		pix_ch.blue = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		apb_read_check(REG_FRAME_WIDTH, WIDTH_RESET);
		apb_read_check(REG_FRAME_HEIGHT, HEIGHT_RESET);

		// Zero sizes act as one, so each pixel is a whole frame; a black pixel
		// beats nothing and still reports position zero.
		reconfigure('0, '0);
		push_pixel(8'd0, 8'd0, 8'd0);
		push_pixel(8'd255, 8'd255, 8'd255);
		push_pixel(8'd255, 8'd0, 8'd128);

		// Extremes found late in the frame, then a flat frame where ties keep
		// the earliest pixel.
		reconfigure(13'd3, 13'd2);
		push_pixel(8'd5, 8'd5, 8'd5);
		push_pixel(8'd5, 8'd5, 8'd5);
		push_pixel(8'd255, 8'd0, 8'd0);
		push_pixel(8'd0, 8'd255, 8'd0);
		push_pixel(8'd0, 8'd0, 8'd255);
		push_pixel(8'd255, 8'd255, 8'd255);
		repeat (6) push_pixel(8'd128, 8'd128, 8'd128);

		// Width shrinks under a running row: the row ends at the next pixel.
		reconfigure(13'd4, 13'd2);
		push_pixel(8'd10, 8'd200, 8'd30);
		push_pixel(8'd40, 8'd50, 8'd250);
		reconfigure(13'd2, 13'd2);
		push_pixel(8'd7, 8'd7, 8'd7);
		push_pixel(8'd0, 8'd99, 8'd1);
		push_pixel(8'd60, 8'd60, 8'd60);

		// Oversized width keeps a long row open; narrowing it under the tallest
		// frame closes the row, and the frame runs on over many rows.
		reconfigure(13'h1FFF, 13'd1);
		send_random(16);
		reconfigure(13'd1, 13'd4096);
		send_random(16);

		// Long receiver hold-off while single-pixel frames keep coming, so the
		// report queue fills and pixel requests back up. The first pixel here
		// closes the tall frame.
		reconfigure(13'd1, 13'd1);
		long_hold_req = 1'b1;
		send_random(12);

		// Random sizes, mostly small; some batches stop mid-frame and carry
		// into the next setting.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= RANDOM_ITEMS - 60) begin
				src_idle_en = 1'b0;
				sink_idle_en = 1'b0;
			end
			if ($urandom_range(0, 7) == 0) begin
				w = DIM_W'($urandom_range(7, 40));
				h = 13'd1;
			end else begin
				w = DIM_W'($urandom_range(0, 5));
				h = DIM_W'($urandom_range(1, 4));
			end
			reconfigure(w, h);
			fw = board.eff_dim(w);
			fh = board.eff_dim(h);
			n = fw * fh * $urandom_range(1, 2);
			if ($urandom_range(0, 4) == 0)
				n = $urandom_range(1, fw * fh);
			send_random(n);
			sent += n;
		end

		quiesce();
		if (board.mismatches == 0 && board.awaited.size() == 0) begin
			$display("frame_extreme_pixel_statistics_unit regression: pass");
		end else begin
			$display("frame_extreme_pixel_statistics_unit regression: fail");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/feps_pkg.sv
hdl/feps_if.sv
hdl/feps_cfg.sv
hdl/feps_front.sv
hdl/feps_back.sv
hdl/frame_extreme_pixel_statistics_unit.sv
hdl/feps_checker.sv
tb/sv/frame_extreme_pixel_statistics_unit_tb.sv
